[rtl/core/avsp_pkg.sv]
// avsp_pkg: shared constants, types and colour helpers for the affine palette scan-out
package avsp_pkg;

    // frame geometry
    localparam int TOP_LINES   = 8;
    localparam int MAIN_LINES  = 216;
    localparam int LINE_PIXELS = 240;
    localparam int ROW_BASE    = 8;

    localparam int LC_W  = $clog2(TOP_LINES + MAIN_LINES);
    localparam int COL_W = $clog2(LINE_PIXELS);

    // stores
    localparam int PIX_AW    = 16;
    localparam int PIX_DEPTH = 1 << PIX_AW;
    localparam int TOP_AW    = 11;
    localparam int TOP_DEPTH = 1 << TOP_AW;
    localparam int PAL_AW    = 8;
    localparam int PAL_DEPTH = 1 << PAL_AW;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_PIX_WR = 2'd0,
        ACT_TOP_WR = 2'd1,
        ACT_PAL_WR = 2'd2,
        ACT_EMIT   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_ACROSS_DX = 3'd2,
        CFG_ACROSS_DY = 3'd3,
        CFG_DOWN_DX   = 3'd4,
        CFG_DOWN_DY   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] across_dx;
        logic [15:0] across_dy;
        logic [15:0] down_dx;
        logic [15:0] down_dy;
    } cfg_t;

    // per-pixel tags that travel down the pipe
    typedef struct packed {
        logic       top;
        logic [7:0] row;
        logic       eol;
        logic       eof;
    } scan_meta_t;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    // palette contents after reset: eight full colours, eight half colours, rest white
    function automatic logic [15:0] pal_default(input logic [PAL_AW-1:0] idx);
        logic [7:0] lvl;
        lvl = idx[3] ? 8'h80 : 8'hff;
        if (idx < 8'd16)
        begin
            pal_default = pack565(idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00,
                                  idx[0] ? lvl : 8'h00);
        end
        else
        begin
            pal_default = pack565(8'hff, 8'hff, 8'hff);
        end
    endfunction

endpackage

[rtl/core/avsp_cmd_if.sv]
// avsp_cmd_if: command channel carrying store writes, palette writes and emit requests
interface avsp_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    modport source (output valid, output action, output address, output data,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input action, input address, input data,
                    input red, input green, input blue, output ready);
endinterface

[rtl/core/avsp_pixel_if.sv]
// avsp_pixel_if: pixel channel carrying rgb565 colour and line/frame tags
interface avsp_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] color;
    logic [7:0]  row;
    logic        end_of_line;
    logic        end_of_frame;

    modport source (output valid, output color, output row, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input color, input row, input end_of_line,
                    input end_of_frame, output ready);
endinterface

[rtl/core/affine_vram_scan_palette_out.sv]
// affine_vram_scan_palette_out: affine scan-out of an 8-bit palette frame as rgb565 pixels
//
//  channel  | dir | beat contents                                   | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  cmd      | in  | action, address, data, red, green, blue         | valid/ready
//  pixel    | out | color, row, end_of_line, end_of_frame           | valid/ready
//  cfg      | in  | cfg_we, cfg_index, cfg_data (six step/origin)   | write only
//
//  one cmd beat per clock while cmd.ready is high; an emit beat passes through the
//  pixel store read, palette read and output register, one pixel per clock while
//  pixel.ready is high; after reset a clearing pass zeroes the stores, cmd.ready held low
//  a stalled pixel beat holds in the output register; the two stages behind it
//  keep filling, so the cmd side stops only once all three are occupied
module affine_vram_scan_palette_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    avsp_cmd_if.sink                           cmd,
    avsp_pixel_if.source                       pixel,
    input  logic                               cfg_we,
    input  logic [avsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    avsp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x   <= 16'd0;
            cfg_reg.start_y   <= 16'd0;
            cfg_reg.across_dx <= 16'd256;
            cfg_reg.across_dy <= 16'd0;
            cfg_reg.down_dx   <= 16'd0;
            cfg_reg.down_dy   <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                avsp_pkg::CFG_START_X:   cfg_reg.start_x   <= cfg_data;
                avsp_pkg::CFG_START_Y:   cfg_reg.start_y   <= cfg_data;
                avsp_pkg::CFG_ACROSS_DX: cfg_reg.across_dx <= cfg_data;
                avsp_pkg::CFG_ACROSS_DY: cfg_reg.across_dy <= cfg_data;
                avsp_pkg::CFG_DOWN_DX:   cfg_reg.down_dx   <= cfg_data;
                avsp_pkg::CFG_DOWN_DY:   cfg_reg.down_dy   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass over both pixel stores after reset
    logic                        clr_active_reg;
    logic [avsp_pkg::PIX_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // pipeline occupancy and advance
    logic                 s1_v_reg, s2_v_reg, out_v_reg;
    logic                 out_free, s2_mv, s2_free, s1_mv, s1_free;
    logic                 acc, emit_acc;
    avsp_pkg::scan_meta_t s1_meta_reg, s2_meta_reg;

    always_comb
    begin
        out_free = !out_v_reg || pixel.ready;
        s2_mv    = s2_v_reg && out_free;
        s2_free  = !s2_v_reg || out_free;
        s1_mv    = s1_v_reg && s2_free;
        s1_free  = !s1_v_reg || s2_free;
    end

    // any beat waits for stage one so a palette write never overtakes a pending lookup
    assign cmd.ready = !clr_active_reg && s1_free;
    assign acc       = cmd.valid && cmd.ready;
    assign emit_acc  = acc && (cmd.action == avsp_pkg::ACT_EMIT);

    // scan counters and affine address
    logic [avsp_pkg::PIX_AW-1:0] scan_pix_addr;
    logic [avsp_pkg::TOP_AW-1:0] scan_top_addr;
    avsp_pkg::scan_meta_t        scan_meta;

    avsp_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (emit_acc),
        .cfg      (cfg_reg),
        .pix_addr (scan_pix_addr),
        .top_addr (scan_top_addr),
        .meta     (scan_meta)
    );

    // pixel store and top store, registered reads into stage one
    logic [7:0]                  pix_mem [avsp_pkg::PIX_DEPTH];
    logic [7:0]                  top_mem [avsp_pkg::TOP_DEPTH];
    logic [7:0]                  pix_rd_reg, top_rd_reg;
    logic                        pix_we, top_we;
    logic [avsp_pkg::PIX_AW-1:0] pix_waddr;
    logic [avsp_pkg::TOP_AW-1:0] top_waddr;
    logic [7:0]                  st_wdata;

    always_comb
    begin
        pix_we    = clr_active_reg || (acc && cmd.action == avsp_pkg::ACT_PIX_WR);
        top_we    = clr_active_reg || (acc && cmd.action == avsp_pkg::ACT_TOP_WR);
        pix_waddr = clr_active_reg ? clr_addr_reg : cmd.address;
        top_waddr = clr_active_reg ? clr_addr_reg[avsp_pkg::TOP_AW-1:0]
                                   : cmd.address[avsp_pkg::TOP_AW-1:0];
        st_wdata  = clr_active_reg ? 8'h00 : cmd.data;
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= st_wdata;
        end
        if (emit_acc)
        begin
            pix_rd_reg <= pix_mem[scan_pix_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_waddr] <= st_wdata;
        end
        if (emit_acc)
        begin
            top_rd_reg <= top_mem[scan_top_addr];
        end
    end

    // palette lookup, stage two
    logic [7:0]  s1_idx;
    logic [15:0] pal_color;
    logic        pal_we;

    assign s1_idx = s1_meta_reg.top ? top_rd_reg : pix_rd_reg;
    assign pal_we = acc && (cmd.action == avsp_pkg::ACT_PAL_WR);

    avsp_palette u_palette
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (pal_we),
        .waddr (cmd.address[avsp_pkg::PAL_AW-1:0]),
        .wdata (avsp_pkg::pack565(cmd.red, cmd.green, cmd.blue)),
        .re    (s1_mv),
        .raddr (s1_idx),
        .rdata (pal_color)
    );

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (emit_acc)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_mv)
            begin
                s1_v_reg <= 1'b0;
            end

            if (s1_mv)
            begin
                s2_v_reg <= 1'b1;
            end
            else if (s2_mv)
            begin
                s2_v_reg <= 1'b0;
            end

            if (s2_mv)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    logic [15:0] color_reg;
    logic [7:0]  row_reg;
    logic        eol_reg, eof_reg;

    always_ff @(posedge clk)
    begin
        if (emit_acc)
        begin
            s1_meta_reg <= scan_meta;
        end
        if (s1_mv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s2_mv)
        begin
            color_reg <= pal_color;
            row_reg   <= s2_meta_reg.row;
            eol_reg   <= s2_meta_reg.eol;
            eof_reg   <= s2_meta_reg.eof;
        end
    end

    assign pixel.valid        = out_v_reg;
    assign pixel.color        = color_reg;
    assign pixel.row          = row_reg;
    assign pixel.end_of_line  = eol_reg;
    assign pixel.end_of_frame = eof_reg;

    // checks
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !cmd.ready)
        else $error("command beat taken during clearing pass");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit_acc |=> s1_v_reg)
        else $error("emit beat lost before stage one");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s2_free |=> s1_v_reg && $stable(s1_meta_reg) && $stable(s1_idx))
        else $error("stage one changed while stalled");

    a_eof_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && eof_reg |-> eol_reg)
        else $error("frame end without line end");

endmodule

[rtl/core/avsp_scan.sv]
// avsp_scan: raster counters and 8.8 affine accumulators giving store addresses per pixel
module avsp_scan
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  avsp_pkg::cfg_t               cfg,
    output logic [avsp_pkg::PIX_AW-1:0]  pix_addr,
    output logic [avsp_pkg::TOP_AW-1:0]  top_addr,
    output avsp_pkg::scan_meta_t         meta
);

    logic [avsp_pkg::LC_W-1:0]  lc_reg, lc_next;
    logic [avsp_pkg::COL_W-1:0] col_reg, col_next;
    logic [15:0] line_x_reg, line_x_next, line_y_reg, line_y_next;
    logic [15:0] pixel_x_reg, pixel_x_next, pixel_y_reg, pixel_y_next;

    logic        top, col0, first_main, eol, eof;
    logic [15:0] lx_eff, ly_eff, cur_x, cur_y;

    always_comb
    begin
        top        = lc_reg < avsp_pkg::LC_W'(avsp_pkg::TOP_LINES);
        col0       = col_reg == '0;
        first_main = lc_reg == avsp_pkg::LC_W'(avsp_pkg::TOP_LINES);
        eol        = col_reg == avsp_pkg::COL_W'(avsp_pkg::LINE_PIXELS - 1);
        eof        = eol && (lc_reg ==
                     avsp_pkg::LC_W'(avsp_pkg::TOP_LINES + avsp_pkg::MAIN_LINES - 1));

        // frame origin is picked up at the start of the first main line
        lx_eff = (col0 && first_main) ? cfg.start_x : line_x_reg;
        ly_eff = (col0 && first_main) ? cfg.start_y : line_y_reg;
        cur_x  = col0 ? lx_eff : pixel_x_reg;
        cur_y  = col0 ? ly_eff : pixel_y_reg;

        pix_addr = {cur_y[15:8], cur_x[15:8]};
        top_addr = {lc_reg[2:0], 8'(col_reg)};

        meta.top = top;
        meta.row = 8'(lc_reg) + 8'(avsp_pkg::ROW_BASE);
        meta.eol = eol;
        meta.eof = eof;

        lc_next      = lc_reg;
        col_next     = col_reg;
        line_x_next  = line_x_reg;
        line_y_next  = line_y_reg;
        pixel_x_next = pixel_x_reg;
        pixel_y_next = pixel_y_reg;

        if (step)
        begin
            if (!top)
            begin
                pixel_x_next = cur_x + cfg.across_dx;
                pixel_y_next = cur_y + cfg.across_dy;
                if (eol)
                begin
                    line_x_next = lx_eff + cfg.down_dx;
                    line_y_next = ly_eff + cfg.down_dy;
                end
                else if (col0)
                begin
                    line_x_next = lx_eff;
                    line_y_next = ly_eff;
                end
            end
            if (eol)
            begin
                col_next = '0;
                lc_next  = eof ? '0 : lc_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg      <= '0;
            col_reg     <= '0;
            line_x_reg  <= '0;
            line_y_reg  <= '0;
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
        end
        else
        begin
            lc_reg      <= lc_next;
            col_reg     <= col_next;
            line_x_reg  <= line_x_next;
            line_y_reg  <= line_y_next;
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
        end
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= avsp_pkg::COL_W'(avsp_pkg::LINE_PIXELS - 1))
        else $error("column counter out of range");

    a_lc_range: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= avsp_pkg::LC_W'(avsp_pkg::TOP_LINES + avsp_pkg::MAIN_LINES - 1))
        else $error("line counter out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && eof |=> lc_reg == '0 && col_reg == '0)
        else $error("frame did not wrap to its first pixel");

endmodule

[rtl/core/avsp_palette.sv]
// avsp_palette: 256-entry rgb565 colour lookup with per-entry valid bits over reset colours
module avsp_palette
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [avsp_pkg::PAL_AW-1:0]  waddr,
    input  logic [15:0]                  wdata,
    input  logic                         re,
    input  logic [avsp_pkg::PAL_AW-1:0]  raddr,
    output logic [15:0]                  rdata
);

    logic [15:0]                    mem [avsp_pkg::PAL_DEPTH];
    logic [avsp_pkg::PAL_DEPTH-1:0] vld_reg;
    logic [15:0]                    rd_reg;
    logic                           rd_vld_reg;
    logic [avsp_pkg::PAL_AW-1:0]    rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg     <= mem[raddr];
            rd_vld_reg <= vld_reg[raddr];
            rd_idx_reg <= raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // never-written entries read as their reset colour
    assign rdata = rd_vld_reg ? rd_reg : avsp_pkg::pal_default(rd_idx_reg);

endmodule
